// File: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants of the go-back-N window unit
// Sequence space, field widths, request and result codes, controller states
// and the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned SEQ_MAX    = 7;
  localparam int unsigned SeqW       = 3;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CntW       = 3;
  localparam int unsigned KindW      = 3;
  localparam int unsigned ReqW       = 2;
  localparam int unsigned StoreDepth = SEQ_MAX + 1;

  typedef enum logic [ReqW-1:0] {
    REQ_SEND    = 2'd0,
    REQ_ARRIVE  = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_CKSUM   = 2'd3
  } req_type_e;

  typedef enum logic [KindW-1:0] {
    KIND_TRANSMIT = 3'd0,
    KIND_DELIVER  = 3'd1,
    KIND_DISCARD  = 3'd2,
    KIND_SUPPRESS = 3'd3,
    KIND_REFUSE   = 3'd4
  } out_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_REPLAY = 2'd2
  } gbn_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic replay_start;
    logic replay_step;
  } gbn_cmd_t;

  typedef struct packed {
    req_type_e req;
    logic      have_outstanding;
    logic      replay_last;
  } gbn_status_t;

  // Sequence numbers wrap from SEQ_MAX back to zero.
  function automatic logic [SeqW-1:0] seq_inc(logic [SeqW-1:0] s);
    return (s == SeqW'(SEQ_MAX)) ? '0 : s + SeqW'(1);
  endfunction

endpackage

// File: hw/rtl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl: controller of the go-back-N window unit
// Sequences capture, single-result execution and timeout replay.
// ----------------------------------------------------------------------------
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  gbn_status_t status_i,
  output gbn_cmd_t    cmd_o
);

  gbn_state_e state_q, state_d;
  logic       replay_go;

  assign replay_go = (status_i.req == REQ_TIMEOUT) && status_i.have_outstanding;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = replay_go ? ST_REPLAY : ST_IDLE;
      end
      ST_REPLAY: begin
        if (status_i.replay_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      ST_EXEC: begin
        cmd_o.replay_start = replay_go;
        cmd_o.exec         = !replay_go;
      end
      ST_REPLAY: begin
        cmd_o.replay_step = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A replay is entered only from execution of a timeout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_REPLAY) ##1 (state_q == ST_REPLAY)
      |-> $past(state_q == ST_EXEC) && $past(status_i.req == REQ_TIMEOUT))
    else $error("replay entered without a timeout");

  // Every capture is followed by an execution cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_EXEC))
    else $error("capture not followed by execution");

  // New requests are taken only while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (state_q == ST_IDLE))
    else $error("busy low outside the idle state");

endmodule

// File: hw/rtl/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp: datapath of the go-back-N window unit
// Window pointers, outstanding count, packet store and result registers.
// ----------------------------------------------------------------------------
module gbn_dp
  import gbn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbn_cmd_t          cmd_i,
  output gbn_status_t       status_o,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic [SeqW-1:0]   frame_seq_i,
  input  logic              suppress_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CntW-1:0]   cfg_data_i,
  output logic              out_strobe_o,
  output logic [KindW-1:0]  out_kind_o,
  output logic [SeqW-1:0]   out_seq_o,
  output logic [ByteW-1:0]  out_byte_o,
  output logic [CntW-1:0]   out_outstanding_o,
  output logic              out_last_o
);

  // Captured request.
  req_type_e        req_q;
  logic [ByteW-1:0] byte_q;
  logic [SeqW-1:0]  fseq_q;
  logic             supp_q;

  // Window state.
  logic [CntW-1:0] limit_q;
  logic [SeqW-1:0] next_q, next_d;
  logic [SeqW-1:0] oldest_q, oldest_d;
  logic [SeqW-1:0] expect_q, expect_d;
  logic [CntW-1:0] count_q, count_d;

  // Replay cursor.
  logic [SeqW-1:0] rep_seq_q, rep_seq_d;
  logic [CntW-1:0] rep_left_q, rep_left_d;

  // Result registers.
  logic             strobe_q, strobe_d;
  out_kind_e        kind_q, kind_d;
  logic [SeqW-1:0]  seq_q, seq_d;
  logic [ByteW-1:0] obyte_q, obyte_d;
  logic [CntW-1:0]  ocnt_q, ocnt_d;
  logic             last_q, last_d;

  // Store port.
  logic             ram_we;
  logic             ram_re;
  logic [SeqW-1:0]  ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  logic window_full;

  assign cfg_ready_o = 1'b1;
  assign window_full = (count_q >= limit_q) || (count_q >= CntW'(SEQ_MAX));

  always_comb begin
    next_d     = next_q;
    oldest_d   = oldest_q;
    expect_d   = expect_q;
    count_d    = count_q;
    rep_seq_d  = rep_seq_q;
    rep_left_d = rep_left_q;
    strobe_d   = 1'b0;
    kind_d     = kind_q;
    seq_d      = seq_q;
    obyte_d    = obyte_q;
    ocnt_d     = ocnt_q;
    last_d     = last_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rep_seq_q;

    if (cmd_i.exec) begin
      case (req_q)
        REQ_SEND: begin
          strobe_d = 1'b1;
          seq_d    = next_q;
          last_d   = 1'b1;
          if (window_full) begin
            kind_d  = KIND_REFUSE;
            obyte_d = '0;
            ocnt_d  = count_q;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + CntW'(1);
            next_d  = seq_inc(next_q);
            kind_d  = supp_q ? KIND_SUPPRESS : KIND_TRANSMIT;
            obyte_d = byte_q;
            ocnt_d  = count_q + CntW'(1);
          end
        end
        REQ_ARRIVE: begin
          strobe_d = 1'b1;
          seq_d    = fseq_q;
          last_d   = 1'b1;
          if (fseq_q != expect_q) begin
            kind_d  = KIND_DISCARD;
            obyte_d = '0;
            ocnt_d  = count_q;
          end else begin
            expect_d = seq_inc(expect_q);
            kind_d   = KIND_DELIVER;
            obyte_d  = byte_q;
            ocnt_d   = count_q;
            if (count_q != '0) begin
              count_d  = count_q - CntW'(1);
              oldest_d = seq_inc(oldest_q);
              ocnt_d   = count_q - CntW'(1);
            end
          end
        end
        default: strobe_d = 1'b0;
      endcase
    end

    if (cmd_i.replay_start) begin
      rep_seq_d  = oldest_q;
      rep_left_d = count_q;
      ram_re     = 1'b1;
      ram_raddr  = oldest_q;
    end

    // The read issued last cycle holds the byte of rep_seq_q.
    if (cmd_i.replay_step) begin
      strobe_d   = 1'b1;
      kind_d     = KIND_TRANSMIT;
      seq_d      = rep_seq_q;
      obyte_d    = ram_rdata;
      ocnt_d     = count_q;
      last_d     = (rep_left_q == CntW'(1));
      rep_seq_d  = seq_inc(rep_seq_q);
      rep_left_d = rep_left_q - CntW'(1);
      ram_re     = 1'b1;
      ram_raddr  = seq_inc(rep_seq_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= CntW'(7);
      next_q     <= '0;
      oldest_q   <= '0;
      expect_q   <= '0;
      count_q    <= '0;
      rep_left_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      next_q     <= next_d;
      oldest_q   <= oldest_d;
      expect_q   <= expect_d;
      count_q    <= count_d;
      rep_left_q <= rep_left_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_e'(req_type_i);
      byte_q <= data_byte_i;
      fseq_q <= frame_seq_i;
      supp_q <= suppress_i;
    end
    rep_seq_q <= rep_seq_d;
    kind_q    <= kind_d;
    seq_q     <= seq_d;
    obyte_q   <= obyte_d;
    ocnt_q    <= ocnt_d;
    last_q    <= last_d;
  end

  gbn_ram #(
    .WIDTH (ByteW),
    .DEPTH (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (next_q),
    .wdata_i (byte_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.req              = req_q;
  assign status_o.have_outstanding = (count_q != '0);
  assign status_o.replay_last      = (rep_left_q == CntW'(1));

  assign out_strobe_o      = strobe_q;
  assign out_kind_o        = kind_q;
  assign out_seq_o         = seq_q;
  assign out_byte_o        = obyte_q;
  assign out_outstanding_o = ocnt_q;
  assign out_last_o        = last_q;

  logic [SeqW-1:0] span;
  assign span = next_q - oldest_q;

  // The outstanding frames are exactly those between oldest and next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    span == SeqW'(count_q))
    else $error("outstanding count disagrees with window pointers");

  // A replay step always has a frame left to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.replay_step |-> (rep_left_q != '0))
    else $error("replay step with no frame left");

  // Results of one timeout come in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !last_q) |=> strobe_q)
    else $error("gap inside a replay burst");

endmodule

// File: hw/rtl/go_back_n_window_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_window_unit: go-back-N link window with loopback receiver
// Buffers sent bytes by sequence number, delivers in-order arrivals and
// replays all outstanding frames on a timeout.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Payload
// request   in         start && !busy                 req_type, data_byte,
//                                                     frame_seq, suppress
// result    out        out_strobe_o, one cycle        out_kind, out_seq,
//                                                     out_byte, out_outstanding,
//                                                     out_last
// config    in         cfg_valid_i && cfg_ready_o     cfg_data_i (window_limit)
//
// A send, an arrival or a checksum error keeps busy high in the execution state
// after acceptance; its result, if any, is registered from that state. A timeout
// with n outstanding frames keeps busy high through execution and n replay steps
// and puts out n results on consecutive cycles, paced by one packet store read a
// cycle. Reset clears the window pointers and count, sets window_limit to 7 and
// leaves the packet store as it is. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module go_back_n_window_unit
  import gbn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [ReqW-1:0]  req_type_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic [SeqW-1:0]  frame_seq_i,
  input  logic             suppress_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CntW-1:0]  cfg_data_i,
  output logic             out_strobe_o,
  output logic [KindW-1:0] out_kind_o,
  output logic [SeqW-1:0]  out_seq_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic [CntW-1:0]  out_outstanding_o,
  output logic             out_last_o
);

  gbn_cmd_t    cmd;
  gbn_status_t status;

  gbn_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  gbn_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .req_type_i        (req_type_i),
    .data_byte_i       (data_byte_i),
    .frame_seq_i       (frame_seq_i),
    .suppress_i        (suppress_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .out_strobe_o      (out_strobe_o),
    .out_kind_o        (out_kind_o),
    .out_seq_o         (out_seq_o),
    .out_byte_o        (out_byte_o),
    .out_outstanding_o (out_outstanding_o),
    .out_last_o        (out_last_o)
  );

endmodule
